FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the port checker (ctpt_checker)
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define AST_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, quiet during reset
`define AST_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// what must hold in the cycle after reset is seen
`define AST_RST(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("assertion failed: state after reset");

`endif

FILE: rtl/ctpt_pkg.sv
// ----------------------------------------------------------------------------
// ctpt_pkg
// Shared types, register codes and saturation helpers of the cubic
// trajectory PD tracker.
// ----------------------------------------------------------------------------
package ctpt_pkg;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_POSITION_GAIN = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_VELOCITY_GAIN = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_MAX_VEL_J0    = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MAX_VEL_J1    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_MAX_VEL_J2    = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_MAX_ACC_J0    = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_MAX_ACC_J1    = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_MAX_ACC_J2    = 3'd7;

   localparam logic [31:0] U32_MAX  = 32'hFFFF_FFFF;
   localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
   localparam logic [46:0] COEF_MAX = {47{1'b1}};
   localparam logic [56:0] TERM_LIM = {1'b1, 56'b0};

   // command to the shared arithmetic unit
   typedef struct packed {
      logic start;
      logic div;
   } arith_ctl_type;

   // clamp to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   // product magnitude capped at 2^56
   function automatic logic [56:0] cap_term(input logic [159:0] v);
      if (v > 160'(TERM_LIM)) begin
         return TERM_LIM;
      end else begin
         return v[56:0];
      end
   endfunction

   // coefficient magnitude capped at 2^47-1
   function automatic logic [46:0] coef_sat(input logic [127:0] q);
      if (q[127:47] != '0) begin
         return COEF_MAX;
      end else begin
         return q[46:0];
      end
   endfunction

   // duration ratio capped at 2^32-1
   function automatic logic [31:0] ratio_sat(input logic [127:0] q);
      if (q[127:32] != '0) begin
         return U32_MAX;
      end else begin
         return q[31:0];
      end
   endfunction

endpackage

FILE: rtl/ctpt_if.sv
// ----------------------------------------------------------------------------
// ctpt_req_if / ctpt_rsp_if
// Valid/ready channels carrying plan and tick items in, results out.
// ----------------------------------------------------------------------------
interface ctpt_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [1:0]         joint;
   logic [31:0]        time_now;
   logic signed [31:0] position;
   logic signed [31:0] velocity;
   logic signed [31:0] target_position;
   logic signed [31:0] gravity_torque;

   modport source (output valid, command, joint, time_now, position, velocity,
                   target_position, gravity_torque, input ready);
   modport sink   (input valid, command, joint, time_now, position, velocity,
                   target_position, gravity_torque, output ready);
endinterface

interface ctpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] torque;
   logic signed [31:0] desired_position;
   logic signed [31:0] desired_velocity;
   logic               tracking;

   modport source (output valid, torque, desired_position, desired_velocity, tracking,
                   input ready);
   modport sink   (input valid, torque, desired_position, desired_velocity, tracking,
                   output ready);
endinterface

FILE: rtl/cubic_trajectory_pd_tracker_top.sv
// ----------------------------------------------------------------------------
// cubic_trajectory_pd_tracker_top
// Per-joint cubic trajectory planner and PD torque law in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries plan items (command 0) and servo ticks (command 1); one
//  item is taken when valid and ready are high together. ready is high only
//  while the sequencer is idle. Each item gives exactly one transfer on
//  rsp_chan: zeros for a plan, torque and the desired state for a tick.
//  csr_* writes the gains and per-joint limits; write only while idle.
// Sequencing:
//  A tracking tick takes seven passes through the shared limb multiplier.
//  A tick outside its trajectory takes none. A plan takes one division per
//  joint with a nonzero acceleration limit for the duration and, if that is
//  nonzero, three more for the coefficients, all on the same restoring
//  divider.
// Reset:
//  Synchronous; clears all trajectories (no joint tracking), sets gains to
//  zero and every limit to 1.0.
// Stall:
//  A result waits in the output register until taken; the next item is
//  accepted meanwhile, and its result waits behind the pending one.
// ----------------------------------------------------------------------------
module cubic_trajectory_pd_tracker_top #(
   parameter int JOINTS = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   ctpt_req_if.sink                      req_chan,
   ctpt_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [ctpt_pkg::CSR_AW-1:0]   csr_index,
   input  logic [ctpt_pkg::CSR_DW-1:0]   csr_write_data
);
   import ctpt_pkg::*;

   localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_RAT   = 4'd2;
   localparam logic [3:0] S_RWAIT = 4'd3;
   localparam logic [3:0] S_SETUP = 4'd4;
   localparam logic [3:0] S_ISSUE = 4'd5;
   localparam logic [3:0] S_WAIT  = 4'd6;
   localparam logic [3:0] S_QD    = 4'd7;
   localparam logic [3:0] S_TAU   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   // arithmetic steps
   localparam logic [3:0] STEP_TT  = 4'd0;
   localparam logic [3:0] STEP_A2  = 4'd1;
   localparam logic [3:0] STEP_Q1  = 4'd2;
   localparam logic [3:0] STEP_A3  = 4'd3;
   localparam logic [3:0] STEP_T2  = 4'd4;
   localparam logic [3:0] STEP_M2P = 4'd5;
   localparam logic [3:0] STEP_M3  = 4'd6;
   localparam logic [3:0] STEP_M3P = 4'd7;
   localparam logic [3:0] STEP_M2V = 4'd8;
   localparam logic [3:0] STEP_P   = 4'd9;
   localparam logic [3:0] STEP_D   = 4'd10;

   // configuration
   logic [31:0] kp_ff, kv_ff;
   logic [31:0] vmax_ff [3];
   logic [31:0] amax_ff [3];

   // per-joint trajectory state
   logic [31:0]        start_ff [JOINTS];
   logic [31:0]        end_ff   [JOINTS];
   logic signed [31:0] a0_ff    [JOINTS];
   logic signed [47:0] a2_ff    [JOINTS];
   logic signed [47:0] a3_ff    [JOINTS];

   // accepted item
   logic               cmd_ff;
   logic [1:0]         joint_ff;
   logic [31:0]        now_ff;
   logic signed [31:0] pos_ff, vel_ff, tgt_ff, grav_ff;

   // sequencer and intermediates
   logic [3:0]         state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic [1:0]         k_ff, k_in;
   logic [31:0]        dur_ff, dur_in;
   logic [31:0]        tvar_ff, tvar_in;
   logic [63:0]        tt_ff, tt_in;
   logic [127:0]       p3_ff, p3_in;
   logic [46:0]        a2m_ff, a2m_in;
   logic [56:0]        m2p_ff, m2p_in, m3p_ff, m3p_in;
   logic [57:0]        m2v_ff, m2v_in;
   logic [58:0]        m3v_ff, m3v_in;
   logic [47:0]        pterm_ff, pterm_in, dterm_ff, dterm_in;
   logic signed [31:0] qd_ff, qd_in, dqd_ff, dqd_in, tau_ff, tau_in;
   logic               trk_ff, trk_in;

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_torque_ff, rsp_dpos_ff, rsp_dvel_ff;
   logic               rsp_trk_ff;

   // shared unit
   arith_ctl_type      arith_ctl;
   logic               arith_start, arith_div;
   logic [127:0]       arith_a;
   logic [63:0]        arith_b;
   logic               arith_done;
   logic [191:0]       arith_res;

   logic               req_xfer, rsp_load;
   logic               js_we, coef_we;
   logic [JW-1:0]      jidx;
   logic               jok;
   logic signed [47:0] a2_cur, a3_cur;
   logic               a2_neg, a3_neg;
   logic [47:0]        a2_mag, a3_mag;
   logic signed [33:0] dlt, err_p, err_v;
   logic               d_neg, e_neg, f_neg;
   logic [33:0]        d_mag, e_mag, f_mag;
   logic [35:0]        dm3;
   logic [34:0]        dm2;
   logic [32:0]        end_sum;
   logic [31:0]        end_val, ratio;
   logic signed [63:0] q_sum, v_sum, t_sum, neg_g;
   logic signed [63:0] p_s, d_s;
   logic [46:0]        a3m_new;
   logic signed [47:0] a2_new, a3_new;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0;
         kv_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            vmax_ff[i] <= ONE_Q16;
            amax_ff[i] <= ONE_Q16;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POSITION_GAIN: kp_ff      <= csr_write_data;
            CSR_VELOCITY_GAIN: kv_ff      <= csr_write_data;
            CSR_MAX_VEL_J0:    vmax_ff[0] <= csr_write_data;
            CSR_MAX_VEL_J1:    vmax_ff[1] <= csr_write_data;
            CSR_MAX_VEL_J2:    vmax_ff[2] <= csr_write_data;
            CSR_MAX_ACC_J0:    amax_ff[0] <= csr_write_data;
            CSR_MAX_ACC_J1:    amax_ff[1] <= csr_write_data;
            CSR_MAX_ACC_J2:    amax_ff[2] <= csr_write_data;
            default:           kp_ff      <= kp_ff;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff   <= req_chan.command;
         joint_ff <= req_chan.joint;
         now_ff   <= req_chan.time_now;
         pos_ff   <= req_chan.position;
         vel_ff   <= req_chan.velocity;
         tgt_ff   <= req_chan.target_position;
         grav_ff  <= req_chan.gravity_torque;
      end
   end

   // joint lookup and signed helpers
   assign jidx   = joint_ff[JW-1:0];
   assign jok    = (32'(joint_ff) < 32'(JOINTS));
   assign a2_cur = a2_ff[jidx];
   assign a3_cur = a3_ff[jidx];
   assign a2_neg = a2_cur[47];
   assign a3_neg = a3_cur[47];
   assign a2_mag = a2_neg ? 48'(-a2_cur) : 48'(a2_cur);
   assign a3_mag = a3_neg ? 48'(-a3_cur) : 48'(a3_cur);

   assign dlt   = {{2{tgt_ff[31]}}, tgt_ff} - {{2{pos_ff[31]}}, pos_ff};
   assign d_neg = dlt[33];
   assign d_mag = d_neg ? 34'(-dlt) : 34'(dlt);
   assign dm3   = {2'b0, d_mag} + {1'b0, d_mag, 1'b0};
   assign dm2   = {d_mag, 1'b0};

   assign err_p = {{2{pos_ff[31]}}, pos_ff} - {{2{qd_ff[31]}}, qd_ff};
   assign err_v = {{2{vel_ff[31]}}, vel_ff} - {{2{dqd_ff[31]}}, dqd_ff};
   assign e_neg = err_p[33];
   assign f_neg = err_v[33];
   assign e_mag = e_neg ? 34'(-err_p) : 34'(err_p);
   assign f_mag = f_neg ? 34'(-err_v) : 34'(err_v);

   assign end_sum = {1'b0, now_ff} + {1'b0, dur_ff};
   assign end_val = (dur_ff == '0) ? now_ff : (end_sum[32] ? U32_MAX : end_sum[31:0]);
   assign ratio   = ratio_sat(arith_res[127:0]);

   // spline sums and torque law
   assign q_sum = {{32{a0_ff[jidx][31]}}, a0_ff[jidx]}
                + (a2_neg ? -$signed({7'b0, m2p_ff}) : $signed({7'b0, m2p_ff}))
                + (a3_neg ? -$signed({7'b0, m3p_ff}) : $signed({7'b0, m3p_ff}));
   assign v_sum = (a2_neg ? -$signed({6'b0, m2v_ff}) : $signed({6'b0, m2v_ff}))
                + (a3_neg ? -$signed({5'b0, m3v_ff}) : $signed({5'b0, m3v_ff}));
   assign neg_g = -{{32{grav_ff[31]}}, grav_ff};
   assign p_s   = e_neg ? -$signed({16'b0, pterm_ff}) : $signed({16'b0, pterm_ff});
   assign d_s   = f_neg ? -$signed({16'b0, dterm_ff}) : $signed({16'b0, dterm_ff});
   assign t_sum = neg_g - p_s - d_s;

   // final coefficients of a plan
   assign a3m_new = coef_sat(arith_res[127:0]);
   assign a2_new  = d_neg ? -$signed({1'b0, a2m_ff}) : $signed({1'b0, a2m_ff});
   assign a3_new  = d_neg ? $signed({1'b0, a3m_new}) : -$signed({1'b0, a3m_new});

   // command to the shared unit
   assign arith_ctl = '{start: arith_start, div: arith_div};

   // operand selection for the shared unit
   always_comb begin
      arith_a   = '0;
      arith_b   = '0;
      arith_div = 1'b0;
      if (state_ff == S_RAT) begin
         arith_a   = {80'b0, vmax_ff[k_ff], 16'b0};
         arith_b   = {32'b0, amax_ff[k_ff]};
         arith_div = 1'b1;
      end else begin
         unique case (step_ff)
            STEP_TT: begin
               arith_a = {96'b0, dur_ff};
               arith_b = {32'b0, dur_ff};
            end
            STEP_A2: begin
               arith_a   = {60'b0, dm3, 32'b0};
               arith_b   = tt_ff;
               arith_div = 1'b1;
            end
            STEP_Q1: begin
               arith_a   = {45'b0, dm2, 48'b0};
               arith_b   = {32'b0, dur_ff};
               arith_div = 1'b1;
            end
            STEP_A3: begin
               arith_a   = p3_ff;
               arith_b   = tt_ff;
               arith_div = 1'b1;
            end
            STEP_T2: begin
               arith_a = {96'b0, tvar_ff};
               arith_b = {32'b0, tvar_ff};
            end
            STEP_M2P: begin
               arith_a = {64'b0, tt_ff};
               arith_b = {16'b0, a2_mag};
            end
            STEP_M3: begin
               arith_a = {64'b0, tt_ff};
               arith_b = {16'b0, a3_mag};
            end
            STEP_M3P: begin
               arith_a = p3_ff;
               arith_b = {32'b0, tvar_ff};
            end
            STEP_M2V: begin
               arith_a = {96'b0, tvar_ff};
               arith_b = {16'b0, a2_mag};
            end
            STEP_P: begin
               arith_a = {96'b0, kp_ff};
               arith_b = {30'b0, e_mag};
            end
            STEP_D: begin
               arith_a = {96'b0, kv_ff};
               arith_b = {30'b0, f_mag};
            end
            default: begin
               arith_a = '0;
               arith_b = '0;
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      k_in        = k_ff;
      dur_in      = dur_ff;
      tvar_in     = tvar_ff;
      tt_in       = tt_ff;
      p3_in       = p3_ff;
      a2m_in      = a2m_ff;
      m2p_in      = m2p_ff;
      m3p_in      = m3p_ff;
      m2v_in      = m2v_ff;
      m3v_in      = m3v_ff;
      pterm_in    = pterm_ff;
      dterm_in    = dterm_ff;
      qd_in       = qd_ff;
      dqd_in      = dqd_ff;
      tau_in      = tau_ff;
      trk_in      = trk_ff;
      js_we       = 1'b0;
      coef_we     = 1'b0;
      arith_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            qd_in  = '0;
            dqd_in = '0;
            trk_in = 1'b0;
            tau_in = '0;
            if (!cmd_ff && jok) begin
               k_in     = '0;
               dur_in   = U32_MAX;
               state_in = S_RAT;
            end else if (!cmd_ff) begin
               state_in = S_OUT;
            end else if (jok && now_ff < end_ff[jidx]) begin
               tvar_in  = (now_ff >= start_ff[jidx]) ? now_ff - start_ff[jidx] : '0;
               step_in  = STEP_T2;
               state_in = S_ISSUE;
            end else begin
               tau_in   = sat32(neg_g);
               state_in = S_OUT;
            end
         end
         S_RAT: begin
            // duration is the smallest limit ratio over joints with nonzero amax
            if (32'(k_ff) >= 32'(JOINTS)) begin
               state_in = S_SETUP;
            end else if (amax_ff[k_ff] == '0) begin
               k_in = k_ff + 2'd1;
            end else begin
               arith_start = 1'b1;
               state_in = S_RWAIT;
            end
         end
         S_RWAIT: begin
            if (arith_done) begin
               if (ratio < dur_ff) begin
                  dur_in = ratio;
               end
               k_in     = k_ff + 2'd1;
               state_in = S_RAT;
            end
         end
         S_SETUP: begin
            js_we = 1'b1;
            if (dur_ff == '0) begin
               state_in = S_OUT;
            end else begin
               step_in  = STEP_TT;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            arith_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (arith_done) begin
               step_in  = step_ff + 4'd1;
               state_in = S_ISSUE;
               unique case (step_ff)
                  STEP_TT:  tt_in  = arith_res[63:0];
                  STEP_A2:  a2m_in = coef_sat(arith_res[127:0]);
                  STEP_Q1:  p3_in  = arith_res[127:0];
                  STEP_A3: begin
                     coef_we  = 1'b1;
                     state_in = S_OUT;
                  end
                  STEP_T2:  tt_in  = arith_res[63:0];
                  STEP_M2P: m2p_in = cap_term(arith_res[191:32]);
                  STEP_M3: begin
                     p3_in  = arith_res[127:0];
                     m3v_in = {2'b0, cap_term(arith_res[191:32])}
                            + {1'b0, cap_term(arith_res[191:32]), 1'b0};
                  end
                  STEP_M3P: m3p_in = cap_term({16'b0, arith_res[191:48]});
                  STEP_M2V: begin
                     m2v_in   = {cap_term(arith_res[175:16]), 1'b0};
                     state_in = S_QD;
                  end
                  STEP_P:   pterm_in = arith_res[63:16];
                  STEP_D: begin
                     dterm_in = arith_res[63:16];
                     state_in = S_TAU;
                  end
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_QD: begin
            qd_in    = sat32(q_sum);
            dqd_in   = sat32(v_sum);
            step_in  = STEP_P;
            state_in = S_ISSUE;
         end
         S_TAU: begin
            tau_in   = sat32(t_sum);
            trk_in   = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_TT;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff   <= dur_in;
      tvar_ff  <= tvar_in;
      tt_ff    <= tt_in;
      p3_ff    <= p3_in;
      a2m_ff   <= a2m_in;
      m2p_ff   <= m2p_in;
      m3p_ff   <= m3p_in;
      m2v_ff   <= m2v_in;
      m3v_ff   <= m3v_in;
      pterm_ff <= pterm_in;
      dterm_ff <= dterm_in;
      qd_ff    <= qd_in;
      dqd_ff   <= dqd_in;
      tau_ff   <= tau_in;
      trk_ff   <= trk_in;
   end

   // trajectory state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < JOINTS; i++) begin
            start_ff[i] <= '0;
            end_ff[i]   <= '0;
            a0_ff[i]    <= '0;
            a2_ff[i]    <= '0;
            a3_ff[i]    <= '0;
         end
      end else if (js_we) begin
         start_ff[jidx] <= now_ff;
         end_ff[jidx]   <= end_val;
         a0_ff[jidx]    <= pos_ff;
         a2_ff[jidx]    <= '0;
         a3_ff[jidx]    <= '0;
      end else if (coef_we) begin
         a2_ff[jidx] <= a2_new;
         a3_ff[jidx] <= a3_new;
      end
   end

   ctpt_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arith_ctl),
      .opa    (arith_a),
      .opb    (arith_b),
      .done   (arith_done),
      .result (arith_res)
   );

   // output register
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_torque_ff <= tau_ff;
         rsp_dpos_ff   <= qd_ff;
         rsp_dvel_ff   <= dqd_ff;
         rsp_trk_ff    <= trk_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.torque           = rsp_torque_ff;
   assign rsp_chan.desired_position = rsp_dpos_ff;
   assign rsp_chan.desired_velocity = rsp_dvel_ff;
   assign rsp_chan.tracking         = rsp_trk_ff;

endmodule

FILE: rtl/ctpt_arith.sv
// ----------------------------------------------------------------------------
// ctpt_arith
// Shared multi-cycle unit: 128x64 multiply from 32x32 limb products, or
// 128/64 restoring division at one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctpt_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  ctpt_pkg::arith_ctl_type ctl,
   input  logic [127:0]            opa,
   input  logic [63:0]             opb,
   output logic                    done,
   output logic [191:0]            result
);
   import ctpt_pkg::*;

   logic         busy_ff, busy_in;
   logic         div_ff, div_in;
   logic         done_ff, done_in;
   logic         pvld_ff, pvld_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic [2:0]   off_ff, off_in;
   logic [63:0]  prod_ff, prod_in;
   logic [127:0] opa_ff, opa_in;
   logic [63:0]  opb_ff, opb_in;
   logic [191:0] acc_ff, acc_in;

   logic [31:0]  limb_a, limb_b;
   logic [63:0]  rem_sh;
   logic         rem_cy, q_bit;

   // limb selection for the multiply schedule
   assign limb_a = opa_ff[{cnt_ff[1:0], 5'b0} +: 32];
   assign limb_b = opb_ff[{cnt_ff[2], 5'b0} +: 32];

   // one restoring division step
   assign rem_cy = acc_ff[191];
   assign rem_sh = {acc_ff[190:128], acc_ff[127]};
   assign q_bit  = rem_cy || (rem_sh >= opb_ff);

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      pvld_in = 1'b0;
      cnt_in  = cnt_ff;
      off_in  = off_ff;
      prod_in = prod_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      acc_in  = acc_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.div;
         cnt_in  = '0;
         opa_in  = opa;
         opb_in  = opb;
         acc_in  = ctl.div ? {64'b0, opa} : '0;
      end else if (busy_ff && div_ff) begin
         acc_in = {(q_bit ? rem_sh - opb_ff : rem_sh), acc_ff[126:0], q_bit};
         cnt_in = cnt_ff + 8'd1;
         if (cnt_ff == 8'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         // issue a limb product, accumulate the one before
         if (cnt_ff < 8'd8) begin
            prod_in = limb_a * limb_b;
            off_in  = 3'({1'b0, cnt_ff[1:0]} + {2'b0, cnt_ff[2]});
            pvld_in = 1'b1;
            cnt_in  = cnt_ff + 8'd1;
         end
         if (pvld_ff) begin
            acc_in = acc_ff + (192'(prod_ff) << {off_ff, 5'b0});
         end
         if (pvld_ff && cnt_ff == 8'd8) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pvld_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pvld_ff <= pvld_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      off_ff  <= off_in;
      prod_ff <= prod_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      acc_ff  <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

FILE: rtl/ctpt_checker.sv
// ----------------------------------------------------------------------------
// ctpt_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_torque,
   input logic [31:0] rsp_desired_position,
   input logic [31:0] rsp_desired_velocity,
   input logic        rsp_tracking
);

   // a stalled result holds
   `AST_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_torque) && $stable(rsp_tracking))

   // off-trajectory results carry no desired state
   `AST_IMPL(a_idle_zero, rsp_valid && !rsp_tracking, rsp_desired_position == 32'd0 && rsp_desired_velocity == 32'd0)

   // one item at a time: busy after each transfer in
   `AST_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // reset leaves the block idle with nothing pending
   `AST_RST(a_reset_quiet, !rsp_valid && req_ready)

endmodule

bind cubic_trajectory_pd_tracker_top ctpt_checker u_ctpt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_torque           (rsp_chan.torque),
   .rsp_desired_position (rsp_chan.desired_position),
   .rsp_desired_velocity (rsp_chan.desired_velocity),
   .rsp_tracking         (rsp_chan.tracking)
);

FILE: dv/ctpt_tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctpt_tracker_checker
// Watches the request, result and register ports of the trajectory tracker.
// It keeps its own copy of gains, limits and per-joint splines, works out the
// torque and desired state of every accepted item, and compares each result
// transfer field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module ctpt_tracker_checker
   import ctpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   ctpt_req_if                 req,
   ctpt_rsp_if                 rsp,
   input  logic                csr_write_enable,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_write_data,
   output int                  fail_count,
   output int                  pending
);

   typedef struct packed {
      logic signed [31:0] torque;
      logic signed [31:0] des_pos;
      logic signed [31:0] des_vel;
      logic               tracking;
   } torque_result_type;

   torque_result_type torque_q[$];
   int                mismatches;

   // shadow registers
   logic [31:0] kp, kv;
   logic [31:0] vmax [3];
   logic [31:0] amax [3];

   // per-joint spline
   logic [31:0] start_t [3];
   logic [31:0] end_t   [3];
   longint      coef_c  [3];
   longint      coef_2  [3];
   longint      coef_3  [3];

   assign fail_count = mismatches;

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // floor(p / 2^s) capped at 2^56
   function automatic logic [63:0] capped_shift(input logic [191:0] p, input int s);
      logic [191:0] v;
      v = p >> s;
      if (v > 192'(TERM_LIM)) return 64'(TERM_LIM);
      return v[63:0];
   endfunction

   // sign-magnitude gain product
   function automatic longint gain_term(input logic [31:0] gain, input longint x);
      logic [191:0] mag;
      longint       m;
      mag = (x < 0) ? 192'(-x) : 192'(x);
      m = longint'(capped_shift(192'(gain) * mag, 16));
      return (x < 0) ? -m : m;
   endfunction

   function automatic longint coef_clip(input logic [191:0] q);
      if (q > 192'(COEF_MAX)) return longint'(COEF_MAX);
      return longint'(q[63:0]);
   endfunction

   // new spline for one joint
   task automatic plan_joint(input int j, input logic [31:0] now,
                             input logic signed [31:0] q, input logic signed [31:0] tgt);
      logic [47:0]  ratio;
      logic [31:0]  dur;
      logic [32:0]  fin;
      longint       d;
      logic [191:0] dm, tw;
      longint       m2, m3;
      dur = U32_MAX;
      for (int k = 0; k < 3; k++) begin
         if (amax[k] == 0) ratio = 48'(U32_MAX);
         else ratio = {vmax[k], 16'b0} / amax[k];
         if (ratio > 48'(U32_MAX)) ratio = 48'(U32_MAX);
         if (ratio[31:0] < dur) dur = ratio[31:0];
      end
      start_t[j] = now;
      coef_c[j]  = longint'(q);
      coef_2[j]  = 0;
      coef_3[j]  = 0;
      fin = 33'(now) + 33'(dur);
      end_t[j] = fin[32] ? U32_MAX : fin[31:0];
      if (dur == 0) begin
         end_t[j] = now;
      end else begin
         d  = longint'(tgt) - longint'(q);
         dm = (d < 0) ? 192'(-d) : 192'(d);
         tw = 192'(dur);
         m2 = coef_clip((dm * 3 << 32) / (tw * tw));
         m3 = coef_clip((dm * 2 << 48) / (tw * tw * tw));
         coef_2[j] = (d < 0) ? -m2 : m2;
         coef_3[j] = (d < 0) ? m3 : -m3;
      end
   endtask

   // torque and desired state of a servo tick
   function automatic torque_result_type tick_result(input logic [1:0] j,
         input logic [31:0] now, input logic signed [31:0] q,
         input logic signed [31:0] dq, input logic signed [31:0] g);
      torque_result_type r;
      logic [191:0]      t, a2m, a3m;
      longint            s2, s3, m2p, m3p, m2v, m3v, qd, dqd;
      r = '0;
      r.torque = clamp32(-longint'(g));
      if (j < 3 && now < end_t[j]) begin
         t   = (now >= start_t[j]) ? 192'(now - start_t[j]) : '0;
         a2m = (coef_2[j] < 0) ? 192'(-coef_2[j]) : 192'(coef_2[j]);
         a3m = (coef_3[j] < 0) ? 192'(-coef_3[j]) : 192'(coef_3[j]);
         s2  = (coef_2[j] < 0) ? -1 : 1;
         s3  = (coef_3[j] < 0) ? -1 : 1;
         m2p = longint'(capped_shift(t * t * a2m, 32));
         m3p = longint'(capped_shift(t * t * t * a3m, 48));
         m2v = 2 * longint'(capped_shift(t * a2m, 16));
         m3v = 3 * longint'(capped_shift(t * t * a3m, 32));
         qd  = clamp32(coef_c[j] + s2 * m2p + s3 * m3p);
         dqd = clamp32(s2 * m2v + s3 * m3v);
         r.des_pos  = qd[31:0];
         r.des_vel  = dqd[31:0];
         r.torque   = clamp32(-longint'(g) - gain_term(kp, longint'(q) - qd)
                              - gain_term(kv, longint'(dq) - dqd));
         r.tracking = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("tb: %0t mismatch on %s: expected %h, got %h", $time, field, want, got);
      mismatches++;
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      torque_result_type want;
      if (reset) begin
         kp = 0;
         kv = 0;
         for (int k = 0; k < 3; k++) begin
            vmax[k] = ONE_Q16;  amax[k] = ONE_Q16;
            start_t[k] = 0;     end_t[k] = 0;
            coef_c[k] = 0;      coef_2[k] = 0;  coef_3[k] = 0;
         end
         torque_q.delete();
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_POSITION_GAIN: kp = csr_write_data;
               CSR_VELOCITY_GAIN: kv = csr_write_data;
               CSR_MAX_VEL_J0:    vmax[0] = csr_write_data;
               CSR_MAX_VEL_J1:    vmax[1] = csr_write_data;
               CSR_MAX_VEL_J2:    vmax[2] = csr_write_data;
               CSR_MAX_ACC_J0:    amax[0] = csr_write_data;
               CSR_MAX_ACC_J1:    amax[1] = csr_write_data;
               CSR_MAX_ACC_J2:    amax[2] = csr_write_data;
               default: ;
            endcase
         end
         // request transfer
         if (req.valid && req.ready) begin
            if (req.command == 1'b0) begin
               if (req.joint < 3) begin
                  plan_joint(req.joint, req.time_now, req.position, req.target_position);
               end
               torque_q.push_back('0);
            end else begin
               torque_q.push_back(tick_result(req.joint, req.time_now, req.position,
                                              req.velocity, req.gravity_torque));
            end
         end
         // result transfer
         if (rsp.valid && rsp.ready) begin
            if (torque_q.size() == 0) begin
               $display("tb: %0t result transfer with nothing expected", $time);
               mismatches++;
            end else begin
               want = torque_q.pop_front();
               if (rsp.torque !== want.torque)
                  report_mismatch("torque", want.torque, rsp.torque);
               if (rsp.desired_position !== want.des_pos)
                  report_mismatch("desired_position", want.des_pos, rsp.desired_position);
               if (rsp.desired_velocity !== want.des_vel)
                  report_mismatch("desired_velocity", want.des_vel, rsp.desired_velocity);
               if (rsp.tracking !== want.tracking)
                  report_mismatch("tracking", 32'(want.tracking), 32'(rsp.tracking));
            end
         end
      end
      pending <= torque_q.size();
   end

endmodule

FILE: dv/cubic_trajectory_pd_tracker_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_trajectory_pd_tracker_top_test
// Drives plans and servo ticks into the tracker under several gain and limit
// settings and flow-control patterns; the checker beside the block predicts
// and compares every result. Ends with a verdict once all results are in.
// ----------------------------------------------------------------------------
module cubic_trajectory_pd_tracker_top_test;
   import ctpt_pkg::*;

   localparam int CMD_PLAN  = 0;
   localparam int CMD_TICK  = 1;
   localparam int MAX_CYCLES = 4_000_000;
   localparam int PHASE_ITEMS = 200;
   localparam int HOLD_CYCLES = 2500;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [CSR_AW-1:0]   csr_index;
   logic [CSR_DW-1:0]   csr_write_data;
   int                  fail_count;
   int                  pending;
   int                  cycles = 0;

   // flow-control modes, set by the stimulus
   logic                sender_idle = 1'b0;
   logic                receiver_stall = 1'b0;
   int                  idle_pct = 63;
   int                  hold_token = 0;
   int                  hold_seen;
   int                  hold_left;

   // stimulus-side view of the trajectories, used to aim tick times
   logic [31:0]         vmax_cfg [3];
   logic [31:0]         amax_cfg [3];
   logic [31:0]         plan_start [3];

   ctpt_req_if req ();
   ctpt_rsp_if rsp ();

   cubic_trajectory_pd_tracker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req),
      .rsp_chan         (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   ctpt_tracker_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b1;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !(receiver_stall && $urandom_range(99) < idle_pct);
      end
   end

   function automatic logic [31:0] trajectory_length();
      logic [47:0] r;
      logic [31:0] dur;
      dur = U32_MAX;
      for (int k = 0; k < 3; k++) begin
         r = {vmax_cfg[k], 16'b0} / amax_cfg[k];
         if (r > 48'(U32_MAX)) r = 48'(U32_MAX);
         if (r[31:0] < dur) dur = r[31:0];
      end
      return dur;
   endfunction

   // mostly modest angles, sometimes full range or an extreme
   function automatic logic [31:0] angle_value();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0) return 32'h7FFF_FFFF;
      if (pick == 1) return 32'h8000_0000;
      if (pick < 5) return $urandom;
      return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
   endfunction

   task automatic csr_write(input logic [CSR_AW-1:0] idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx >= CSR_MAX_VEL_J0 && idx <= CSR_MAX_VEL_J2)
         vmax_cfg[idx - CSR_MAX_VEL_J0] = value;
      if (idx >= CSR_MAX_ACC_J0)
         amax_cfg[idx - CSR_MAX_ACC_J0] = value;
      @(posedge clock);
   endtask

   task automatic load_setting(input logic [31:0] pgain, input logic [31:0] vgain,
                               input logic [31:0] v0, input logic [31:0] v1,
                               input logic [31:0] v2, input logic [31:0] c0,
                               input logic [31:0] c1, input logic [31:0] c2);
      csr_write(CSR_POSITION_GAIN, pgain);
      csr_write(CSR_VELOCITY_GAIN, vgain);
      csr_write(CSR_MAX_VEL_J0, v0);
      csr_write(CSR_MAX_VEL_J1, v1);
      csr_write(CSR_MAX_VEL_J2, v2);
      csr_write(CSR_MAX_ACC_J0, c0);
      csr_write(CSR_MAX_ACC_J1, c1);
      csr_write(CSR_MAX_ACC_J2, c2);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // one request transfer, with an optional idle gap in front
   task automatic send_item(input int cmd, input logic [1:0] j, input logic [31:0] tn,
                            input logic [31:0] pos, input logic [31:0] vel,
                            input logic [31:0] tgt, input logic [31:0] grav);
      if (sender_idle && $urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid           <= 1'b1;
      req.command         <= cmd[0];
      req.joint           <= j;
      req.time_now        <= tn;
      req.position        <= pos;
      req.velocity        <= vel;
      req.target_position <= tgt;
      req.gravity_torque  <= grav;
      if (cmd == CMD_PLAN && j < 3) plan_start[j] = tn;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // wait until every expected result has come back
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // random traffic: well-formed plan/tick runs with some noise
   task automatic random_items(input int count);
      logic [31:0] dur, span, tn;
      logic [32:0] reach;
      logic [1:0]  j;
      int          pick;
      dur = trajectory_length();
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         j = 2'($urandom_range(2));
         if (pick < 12) begin
            if ($urandom_range(19) == 0) j = 2'd3;
            tn = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(32'h0100_0000));
            send_item(CMD_PLAN, j, tn, angle_value(), $urandom, angle_value(), $urandom);
         end else if (pick < 90) begin
            reach = 33'(dur) + 33'(dur >> 2) + 33'd2;
            span = reach[32] ? U32_MAX : reach[31:0];
            reach = 33'(plan_start[j]) + 33'($urandom_range(span));
            tn = reach[32] ? U32_MAX : reach[31:0];
            if ($urandom_range(15) == 0) tn = plan_start[j] - 32'($urandom_range(1, 4096));
            send_item(CMD_TICK, j, tn, angle_value(), angle_value(), $urandom,
                      angle_value());
         end else begin
            send_item($urandom_range(1), 2'($urandom_range(3)), $urandom, $urandom,
                      $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req.valid        <= 1'b0;
      req.command      <= 1'b0;
      req.joint        <= '0;
      req.time_now     <= '0;
      req.position     <= '0;
      req.velocity     <= '0;
      req.target_position <= '0;
      req.gravity_torque  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      for (int k = 0; k < 3; k++) begin
         vmax_cfg[k] = ONE_Q16;
         amax_cfg[k] = ONE_Q16;
         plan_start[k] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: gains zero, unit limits
      random_items(PHASE_ITEMS / 2);
      drain();

      // unit limits, gains 1.0 and 0.5: directed corners, then random, long hold-off
      load_setting(ONE_Q16, 32'h0000_8000, ONE_Q16, ONE_Q16, ONE_Q16,
                   ONE_Q16, ONE_Q16, ONE_Q16);
      send_item(CMD_PLAN, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 32'h0);
      send_item(CMD_TICK, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(CMD_TICK, 2'd0, 32'h0001_8000, 32'h0001_0000, 32'h0002_0000, 32'h0,
                32'h0000_4000);
      send_item(CMD_TICK, 2'd0, 32'h0001_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
      // exactly at the end: no longer tracking
      send_item(CMD_TICK, 2'd0, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      // before the start time: t taken as zero
      send_item(CMD_TICK, 2'd0, 32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(CMD_TICK, 2'd0, U32_MAX, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
      send_item(CMD_PLAN, 2'd1, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
      send_item(CMD_TICK, 2'd1, 32'h0000_4000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                32'h8000_0000);
      send_item(CMD_TICK, 2'd1, 32'h0000_C000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                32'h7FFF_FFFF);
      send_item(CMD_PLAN, 2'd2, 32'hFFFF_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
                32'h0);
      send_item(CMD_TICK, 2'd2, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0, 32'h0);
      // zero distance
      send_item(CMD_PLAN, 2'd0, 32'h0000_0100, 32'h0003_0000, 32'h0, 32'h0003_0000,
                32'h0);
      send_item(CMD_TICK, 2'd0, 32'h0000_8000, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
      // joint index out of range
      send_item(CMD_PLAN, 2'd3, 32'h0, 32'h0001_0000, 32'h0, 32'h0005_0000, 32'h0);
      send_item(CMD_TICK, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
      send_item(CMD_TICK, 2'd3, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      hold_token = hold_token + 1;
      random_items(PHASE_ITEMS);
      drain();

      // saturating ratio on joint 0, full gains; sender pauses mid-phase
      load_setting(U32_MAX, U32_MAX, U32_MAX, 32'h0002_0000, 32'h0003_0000,
                   32'h0000_0001, 32'h0004_0000, ONE_Q16);
      sender_idle = 1'b1;
      random_items(PHASE_ITEMS / 2);
      drain();
      random_items(PHASE_ITEMS / 2);
      drain();

      // zero duration: smallest velocity limit, largest acceleration limit
      load_setting(32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                   U32_MAX, U32_MAX, U32_MAX);
      sender_idle = 1'b0;
      receiver_stall = 1'b1;
      random_items(PHASE_ITEMS / 2);
      drain();

      // longest duration, end time saturates; both sides idle now and then
      load_setting(32'h0000_0200, 32'h0000_0040, U32_MAX, U32_MAX, U32_MAX,
                   32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      sender_idle = 1'b1;
      idle_pct = 13;
      random_items(PHASE_ITEMS / 2);
      drain();

      // random settings, cycling through the flow-control modes
      for (int ph = 0; ph < 4; ph++) begin
         load_setting($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0004_0000),
                      $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0004_0000),
                      $urandom_range(1, 32'h0004_0000), $urandom_range(1, 32'h0004_0000),
                      $urandom_range(1, 32'h0004_0000), $urandom_range(1, 32'h0004_0000),
                      $urandom_range(1, 32'h0004_0000), $urandom_range(1, 32'h0004_0000));
         sender_idle    = ph[0];
         receiver_stall = ph[1];
         idle_pct       = (ph == 3) ? 13 : 63;
         random_items(PHASE_ITEMS);
         drain();
      end

      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
